>>> design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, sizes and helper functions for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Largest memory is 2^MAX_ORDER units, so the list never holds more blocks
    localparam int MAX_ORDER  = 6;
    localparam int DEPTH      = 1 << MAX_ORDER;
    localparam int IDX_W      = MAX_ORDER;
    localparam int LEN_W      = MAX_ORDER + 1;
    localparam int OWNER_BITS = 16;
    localparam int ORD_W      = 3;
    localparam int WANT_W     = 5;
    localparam int SIZE_W     = 16;
    localparam int ENTRY_W    = OWNER_BITS + ORD_W;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_TOTAL_ORDER = 1'b0;   // register index (paddr[2])

    // Item codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Order a request rounds up to: smallest r with 2^r >= size, size 0 as 1
    function automatic logic [WANT_W-1:0] round_order(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] v;
        logic [WANT_W-1:0] r;
        v = size - SIZE_W'(1);
        r = '0;
        if (size > SIZE_W'(1))
        begin
            for (int i = 0; i < SIZE_W; i++)
            begin
                if (v[i])
                begin
                    r = WANT_W'(i + 1);
                end
            end
        end
        return r;
    endfunction

    // Register value written to total_order saturates at MAX_ORDER
    function automatic logic [ORD_W-1:0] sat_order(input logic [ORD_W-1:0] val);
        return (val > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : val;
    endfunction

endpackage

>>> design/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// Valid/ready channels of the buddy block allocator: requests and results.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [bba_pkg::OWNER_BITS-1:0]   owner_id;
    logic [bba_pkg::SIZE_W-1:0]       request_size;

    modport source (output valid, cmd, owner_id, request_size, input ready);
    modport sink   (input valid, cmd, owner_id, request_size, output ready);
endinterface

interface bba_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bba_pkg::LEN_W-1:0]        block_count;
    logic [bba_pkg::OWNER_BITS-1:0]   block_owner;
    logic                             last_block;

    modport source (output valid, block_count, block_owner, last_block, input ready);
    modport sink   (input valid, block_count, block_owner, last_block, output ready);
endinterface

>>> design/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator keeping an address-ordered block list in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (sink): cmd 0 allocates owner_id a block of request_size units
//   rounded up to a power of two; cmd 1 dumps the block list. rsp channel
//   (source): one beat per block on a dump, with block_count and last_block.
//   APB port: register 0 (total_order) at byte 0; writing it rebuilds the list
//   as one free block. Write it only while the block is idle.
// Timing:
//   One item at a time; req ready is low while an item is being worked on.
//   Allocate: the list scan reads one entry a cycle from the RAM and stops at
//   the first hit, then the tail beyond the chosen block is moved once by the
//   number of splits d (one entry a cycle), the d new buddies are written and
//   the block is stamped, all through the single RAM port pair.
//   Query: S_QRD reads the first entry, then S_QLD loads one beat a cycle while
//   the receiver keeps ready high; a stall holds the output register and the
//   sequencer. The last beat may still wait while the next item is accepted.
// Reset: one free block of order 6; no clearing pass, entry 0 is overlaid
//   with its reset value until first written.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    bba_req_if.sink                           req,
    bba_rsp_if.source                         rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bba_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bba_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bba_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int IDX_W   = bba_pkg::IDX_W;
    localparam int LEN_W   = bba_pkg::LEN_W;
    localparam int ORD_W   = bba_pkg::ORD_W;
    localparam int WANT_W  = bba_pkg::WANT_W;
    localparam int OWN_W   = bba_pkg::OWNER_BITS;
    localparam int ENTRY_W = bba_pkg::ENTRY_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_QRD   = 3'd5;
    localparam logic [2:0] S_QLD   = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [ORD_W-1:0]   total_order_reg, total_order_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovr_reg, ovr_next;
    logic [OWN_W-1:0]   owner_reg, owner_next;
    logic [WANT_W-1:0]  want_reg, want_next;
    logic [LEN_W-1:0]   scan_reg, scan_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [ORD_W-1:0]   d_reg, d_next;
    logic [IDX_W-1:0]   f_reg, f_next;
    logic               mv_valid_reg, mv_valid_next;
    logic [IDX_W-1:0]   mv_dst_reg, mv_dst_next;
    logic [ORD_W-1:0]   j_reg, j_next;
    logic               rd_ovr_reg, rd_ovr_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]   out_count_reg, out_count_next;
    logic [OWN_W-1:0]   out_owner_reg, out_owner_next;
    logic               out_last_reg, out_last_next;

    // RAM ports
    logic               we, re;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;

    // decoded read entry, with the reset overlay on entry 0
    logic [OWN_W-1:0]   rd_owner;
    logic [ORD_W-1:0]   rd_order;
    logic               hit, issue, last_miss, slot_free, cfg_wr;
    logic [LEN_W-1:0]   len_m1;

    bba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (bba_pkg::DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_owner = rd_ovr_reg ? '0 : rdata[ENTRY_W-1:ORD_W];
    assign rd_order = rd_ovr_reg ? total_order_reg : rdata[ORD_W-1:0];
    assign len_m1   = len_reg - LEN_W'(1);

    // scan compare: free block large enough
    assign hit       = chk_valid_reg && (rd_owner == '0)
                       && ({{(WANT_W-ORD_W){1'b0}}, rd_order} >= want_reg);
    assign issue     = !hit && (scan_reg < len_reg);
    assign last_miss = chk_valid_reg && !hit && ({1'b0, chk_idx_reg} == len_m1);
    assign slot_free = !out_valid_reg || rsp.ready;

    // handshake and APB outputs
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.block_count = out_count_reg;
    assign rsp.block_owner = out_owner_reg;
    assign rsp.last_block  = out_last_reg;
    assign pready          = 1'b1;
    assign prdata          = {{(bba_pkg::CFG_DATA_W-ORD_W){1'b0}}, total_order_reg};
    assign cfg_wr          = psel && penable && pwrite;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        total_order_next = total_order_reg;
        len_next         = len_reg;
        ovr_next         = ovr_reg;
        owner_next       = owner_reg;
        want_next        = want_reg;
        scan_next        = scan_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        k_next           = k_reg;
        d_next           = d_reg;
        f_next           = f_reg;
        mv_valid_next    = 1'b0;
        mv_dst_next      = mv_dst_reg;
        j_next           = j_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_count_next   = out_count_reg;
        out_owner_next   = out_owner_reg;
        out_last_next    = out_last_reg;
        we               = 1'b0;
        waddr            = '0;
        wdata            = '0;
        re               = 1'b0;
        raddr            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    owner_next = req.owner_id;
                    want_next  = bba_pkg::round_order(req.request_size);
                    scan_next  = '0;
                    state_next = (req.cmd == bba_pkg::CMD_QUERY) ? S_QRD : S_SCAN;
                end
            end

            // read one entry a cycle, check it the cycle after
            S_SCAN:
            begin
                if (issue)
                begin
                    re             = 1'b1;
                    raddr          = scan_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + LEN_W'(1);
                end
                if (hit)
                begin
                    k_next = chk_idx_reg;
                    d_next = rd_order - want_reg[ORD_W-1:0];
                    f_next = len_m1[IDX_W-1:0];
                    j_next = ORD_W'(1);
                    state_next = (rd_order == want_reg[ORD_W-1:0]) ? S_FIN : S_SHIFT;
                end
                else if (last_miss)
                begin
                    state_next = S_IDLE;
                end
            end

            // move the tail up by d entries, top first
            S_SHIFT:
            begin
                if (mv_valid_reg)
                begin
                    we    = 1'b1;
                    waddr = mv_dst_reg;
                    wdata = rdata;
                end
                if (f_reg > k_reg)
                begin
                    re            = 1'b1;
                    raddr         = f_reg;
                    mv_valid_next = 1'b1;
                    mv_dst_next   = f_reg + IDX_W'(d_reg);
                    f_next        = f_reg - IDX_W'(1);
                end
                else
                begin
                    state_next = S_FILL;
                end
            end

            // free buddies of rising order after the chosen block
            S_FILL:
            begin
                we    = 1'b1;
                waddr = k_reg + IDX_W'(j_reg);
                wdata = {{OWN_W{1'b0}}, want_reg[ORD_W-1:0] + j_reg - ORD_W'(1)};
                j_next = j_reg + ORD_W'(1);
                if (j_reg == d_reg)
                begin
                    state_next = S_FIN;
                end
            end

            // stamp the chosen block
            S_FIN:
            begin
                we         = 1'b1;
                waddr      = k_reg;
                wdata      = {owner_reg, want_reg[ORD_W-1:0]};
                len_next   = len_reg + LEN_W'(d_reg);
                state_next = S_IDLE;
            end

            S_QRD:
            begin
                re         = 1'b1;
                raddr      = '0;
                state_next = S_QLD;
            end

            // load a beat when the output slot frees, prefetch the next entry
            S_QLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = len_reg;
                    out_owner_next = rd_owner;
                    out_last_next  = (scan_reg == len_m1);
                    if (scan_reg == len_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        re        = 1'b1;
                        raddr     = scan_reg[IDX_W-1:0] + IDX_W'(1);
                        scan_next = scan_reg + LEN_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // first write of entry 0 retires the reset overlay
        if (we && (waddr == '0))
        begin
            ovr_next = 1'b0;
        end

        // register write rebuilds the list
        if (cfg_wr && (paddr[2] == bba_pkg::REG_TOTAL_ORDER))
        begin
            total_order_next = bba_pkg::sat_order(pwdata[ORD_W-1:0]);
            len_next         = LEN_W'(1);
            ovr_next         = 1'b1;
        end
    end

    // overlay flag follows the read data
    always_comb
    begin
        rd_ovr_next = rd_ovr_reg;
        if (re)
        begin
            rd_ovr_next = (raddr == '0) && ovr_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            total_order_reg <= ORD_W'(bba_pkg::MAX_ORDER);
            len_reg         <= LEN_W'(1);
            ovr_reg         <= 1'b1;
            chk_valid_reg   <= 1'b0;
            mv_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            rd_ovr_reg      <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            total_order_reg <= total_order_next;
            len_reg         <= len_next;
            ovr_reg         <= ovr_next;
            chk_valid_reg   <= chk_valid_next;
            mv_valid_reg    <= mv_valid_next;
            out_valid_reg   <= out_valid_next;
            rd_ovr_reg      <= rd_ovr_next;
        end
    end

    // working registers and output payload
    always_ff @(posedge clk)
    begin
        owner_reg     <= owner_next;
        want_reg      <= want_next;
        scan_reg      <= scan_next;
        chk_idx_reg   <= chk_idx_next;
        k_reg         <= k_next;
        d_reg         <= d_next;
        f_reg         <= f_next;
        mv_dst_reg    <= mv_dst_next;
        j_reg         <= j_next;
        out_count_reg <= out_count_next;
        out_owner_reg <= out_owner_next;
        out_last_reg  <= out_last_next;
    end

endmodule

>>> design/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [bba_pkg::LEN_W-1:0]         block_count,
    input logic [bba_pkg::OWNER_BITS-1:0]    block_owner,
    input logic                              last_block,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [bba_pkg::CFG_ADDR_W-1:0]    paddr,
    input logic [bba_pkg::CFG_DATA_W-1:0]    pwdata,
    input logic [bba_pkg::CFG_DATA_W-1:0]    prdata
);

    // a stalled beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(block_owner) && $stable(last_block)
                                    && $stable(block_count))
        else $error("result payload changed while stalled");

    // the list never reports an empty or oversized count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (block_count != '0)
                      && (block_count <= bba_pkg::LEN_W'(bba_pkg::DEPTH)))
        else $error("block count out of range");

    // every accepted item takes ready low in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken back to back");

    // total_order reads back saturated after a write
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == bba_pkg::REG_TOTAL_ORDER)
        |=> prdata[bba_pkg::ORD_W-1:0] == bba_pkg::sat_order($past(pwdata[bba_pkg::ORD_W-1:0])))
        else $error("total_order readback mismatch");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .block_count (rsp.block_count),
    .block_owner (rsp.block_owner),
    .last_block  (rsp.last_block),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

>>> tb/sv/bba_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_list_checker
// Watches the request, result and APB channels of the buddy block allocator,
// keeps its own copy of the block list, and checks every listing beat
// against the list as it stood when the dump was accepted.
// ----------------------------------------------------------------------------
module bba_list_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    bba_req_if                             req,
    bba_rsp_if                             rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [bba_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bba_pkg::CFG_DATA_W-1:0] pwdata,
    output int                             mismatches,
    output int                             pending,
    output int                             beats_seen
);

    typedef struct packed {
        logic [bba_pkg::LEN_W-1:0]      count;
        logic [bba_pkg::OWNER_BITS-1:0] owner;
        logic                           last;
    } listing_beat_t;

    // Shadow block list, address order
    logic [bba_pkg::OWNER_BITS-1:0] blk_owner [bba_pkg::DEPTH];
    logic [bba_pkg::ORD_W-1:0]      blk_order [bba_pkg::DEPTH];
    int unsigned                    blk_count;

    // Beats still owed by dumps already accepted
    listing_beat_t listing_q [$];

    // Smallest r with 2^r >= size; size 0 behaves as 1
    function automatic int unsigned order_needed(input logic [bba_pkg::SIZE_W-1:0] size);
        int unsigned r;
        r = 0;
        while (r < 17 && (32'd1 << r) < 32'(size))
        begin
            r++;
        end
        return r;
    endfunction

    // One free block covering the whole memory
    task automatic rebuild_list(input logic [bba_pkg::ORD_W-1:0] mem_order);
        for (int i = 0; i < bba_pkg::DEPTH; i++)
        begin
            blk_owner[i] = '0;
            blk_order[i] = '0;
        end
        blk_order[0] = mem_order;
        blk_count    = 1;
    endtask

    // First fit in address order, then halve down to the wanted order
    task automatic carve_block(input logic [bba_pkg::OWNER_BITS-1:0] owner,
                               input logic [bba_pkg::SIZE_W-1:0] size);
        int unsigned want;
        want = order_needed(size);
        for (int k = 0; k < blk_count; k++)
        begin
            if (blk_owner[k] != '0 || blk_order[k] < want)
            begin
                continue;
            end
            while (blk_order[k] > want && blk_count < bba_pkg::DEPTH)
            begin
                blk_order[k] = blk_order[k] - 1'b1;
                // open a slot: the upper buddy is the copy left at k+1
                for (int f = blk_count; f > k; f--)
                begin
                    blk_owner[f] = blk_owner[f-1];
                    blk_order[f] = blk_order[f-1];
                end
                blk_count++;
            end
            blk_owner[k] = owner;
            return;
        end
    endtask

    // Main watch: config writes, result beats, then accepted items
    always @(posedge clk or negedge rst_n)
    begin : watch
        listing_beat_t beat;
        logic [bba_pkg::ORD_W-1:0] wr_order;
        if (!rst_n)
        begin
            rebuild_list(bba_pkg::ORD_W'(bba_pkg::MAX_ORDER));
            listing_q.delete();
            mismatches = 0;
            beats_seen = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[bba_pkg::CFG_ADDR_W-1:2] == bba_pkg::REG_TOTAL_ORDER)
            begin
                wr_order = pwdata[bba_pkg::ORD_W-1:0];
                if (wr_order > bba_pkg::ORD_W'(bba_pkg::MAX_ORDER))
                begin
                    wr_order = bba_pkg::ORD_W'(bba_pkg::MAX_ORDER);
                end
                rebuild_list(wr_order);
            end

            if (rsp.valid && rsp.ready)
            begin
                beats_seen++;
                if (listing_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: unexpected beat: count=%0d owner=%h last=%b",
                                 $time, rsp.block_count, rsp.block_owner, rsp.last_block);
                    end
                end
                else
                begin
                    beat = listing_q.pop_front();
                    if (rsp.block_count !== beat.count || rsp.block_owner !== beat.owner
                        || rsp.last_block !== beat.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: listing mismatch: exp count=%0d owner=%h last=%b,%s",
                                     $time, beat.count, beat.owner, beat.last, "");
                            $display("    got count=%0d owner=%h last=%b",
                                     rsp.block_count, rsp.block_owner, rsp.last_block);
                        end
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                if (req.cmd == bba_pkg::CMD_QUERY)
                begin
                    for (int k = 0; k < blk_count; k++)
                    begin
                        beat.count = bba_pkg::LEN_W'(blk_count);
                        beat.owner = blk_owner[k];
                        beat.last  = (k + 1 == blk_count);
                        listing_q.push_back(beat);
                    end
                end
                else
                begin
                    carve_block(req.owner_id, req.request_size);
                end
            end

            pending = listing_q.size();
        end
    end

endmodule

>>> tb/sv/tb_buddy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Drives allocate and dump items into the buddy block allocator under random
// back-pressure, rewrites the memory size between phases, and reports the
// verdict from the list checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;

    localparam int CYCLE_LIMIT      = 5000000;
    localparam int SETTLE_CYCLES    = 200;   // covers the longest allocate
    localparam int HOLD_AFTER_BEATS = 60;
    localparam int HOLD_CYCLES      = 400;
    localparam int PHASE_ITEMS      = 37;

    localparam logic [bba_pkg::CFG_ADDR_W-1:0] TOTAL_ORDER_ADDR = 3'd0;
    localparam logic [bba_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR    = 3'd4;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bba_pkg::CFG_ADDR_W-1:0] paddr;
    logic [bba_pkg::CFG_DATA_W-1:0] pwdata;
    logic [bba_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    int mismatches;
    int pending;
    int beats_seen;
    int items_sent;
    int queries_sent;
    int order_writes;
    int cycle_count;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_block_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bba_list_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending),
        .beats_seen (beats_seen)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[buddy_block_allocator] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, calm stretches and one long hold-off
    initial
    begin : rsp_sink
        int  gap;
        int  calm_left;
        bit  held;
        calm_left = 0;
        held      = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (calm_left > 0)
            begin
                gap = 0;
                calm_left--;
            end
            else
            begin
                gap = idle_len();
                if ($urandom_range(0, 24) == 0)
                begin
                    calm_left = $urandom_range(20, 60);
                end
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // long hold-off so the dump backs up and the request side stalls
            if (!held && beats_seen >= HOLD_AFTER_BEATS)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    // APB write: setup then access, ends in the cycle after the access
    task automatic apb_write(input logic [bba_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [bba_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item after an optional gap; returns at the accepting edge
    task automatic offer_item(input logic c, input logic [bba_pkg::OWNER_BITS-1:0] own,
                              input logic [bba_pkg::SIZE_W-1:0] sz, input bit calm);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= c;
        req_ch.owner_id     <= own;
        req_ch.request_size <= sz;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        items_sent++;
        if (c == bba_pkg::CMD_QUERY)
        begin
            queries_sent++;
        end
    endtask

    // Stop sending, let every owed beat arrive, then let a last allocate finish
    task automatic drain_listing();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Rewrite the memory size while idle; upper data bits are noise
    task automatic set_total_order(input logic [bba_pkg::CFG_ADDR_W-1:0] addr,
                                   input logic [bba_pkg::ORD_W-1:0] ord);
        logic [bba_pkg::CFG_DATA_W-1:0] data;
        drain_listing();
        data          = $urandom;
        data[bba_pkg::ORD_W-1:0] = ord;
        apb_write(addr, data);
        order_writes++;
    endtask

    // Random item: mostly allocations that fit the current memory
    task automatic random_item(input int mem_order, input bit calm);
        int                             pick;
        int                             r;
        logic [bba_pkg::OWNER_BITS-1:0] own;
        logic [bba_pkg::SIZE_W-1:0]     sz;
        pick = $urandom_range(0, 99);
        own  = ($urandom_range(0, 9) == 0) ? '0 : bba_pkg::OWNER_BITS'($urandom);
        sz   = bba_pkg::SIZE_W'($urandom);
        if (pick < 20)
        begin
            offer_item(bba_pkg::CMD_QUERY, own, sz, calm);
        end
        else
        begin
            if (pick < 85)
            begin
                r  = $urandom_range(0, mem_order);
                sz = (r == 0) ? bba_pkg::SIZE_W'($urandom_range(0, 1))
                              : bba_pkg::SIZE_W'($urandom_range((1 << (r - 1)) + 1, 1 << r));
            end
            offer_item(bba_pkg::CMD_ALLOC, own, sz, calm);
        end
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int phase_orders [8];
        int eff_order;
        bit calm;
        phase_orders = '{6, 3, 7, 1, 5, 2, 4, 0};
        items_sent   = 0;
        queries_sent = 0;
        order_writes = 0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= bba_pkg::CMD_ALLOC;
        req_ch.owner_id     <= '0;
        req_ch.request_size <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fresh list, size 0 and 1, rounding, no fit, owner zero
        offer_item(bba_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'hFFFF, 16'h0000, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h0001, 16'h0001, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h00A5, 16'h0002, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h5A00, 16'h0003, 1'b0);
        offer_item(bba_pkg::CMD_QUERY, 16'hFFFF, 16'hFFFF, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h0000, 16'h0005, 1'b0);
        // the owner-zero block still looks free and gets taken again
        offer_item(bba_pkg::CMD_ALLOC, 16'h1234, 16'h0008, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h7777, 16'h0040, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h8888, 16'hFFFF, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h2222, 16'h8000, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'hABCD, 16'h0011, 1'b0);
        offer_item(bba_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h4321, 16'h0010, 1'b0);
        offer_item(bba_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0);

        // Oversized order saturates; whole memory in one block
        set_total_order(TOTAL_ORDER_ADDR, 3'd7);
        offer_item(bba_pkg::CMD_ALLOC, 16'hBEEF, 16'h0040, 1'b0);
        offer_item(bba_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h0F0F, 16'h0001, 1'b0);
        offer_item(bba_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0);

        // Unmapped register leaves the list alone
        set_total_order(UNMAPPED_ADDR, 3'd0);
        offer_item(bba_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0);

        // Smallest memory: one unit
        set_total_order(TOTAL_ORDER_ADDR, 3'd0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h0001, 16'h0002, 1'b0);
        offer_item(bba_pkg::CMD_ALLOC, 16'h0003, 16'h0001, 1'b0);
        offer_item(bba_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0);

        // Random phases over a spread of memory sizes
        foreach (phase_orders[p])
        begin
            set_total_order(TOTAL_ORDER_ADDR, bba_pkg::ORD_W'(phase_orders[p]));
            eff_order = (phase_orders[p] > bba_pkg::MAX_ORDER) ? bba_pkg::MAX_ORDER
                                                               : phase_orders[p];
            calm      = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
            begin
                random_item(eff_order, calm);
            end
            offer_item(bba_pkg::CMD_QUERY, bba_pkg::OWNER_BITS'($urandom),
                       bba_pkg::SIZE_W'($urandom), calm);
        end

        drain_listing();
        $display("Run covered %0d items (%0d list dumps) and %0d result beats,",
                 items_sent, queries_sent, beats_seen);
        $display("over %0d register writes with memory sizes from 1 to 64 units.",
                 order_writes);
        if (mismatches == 0)
        begin
            $display("[buddy_block_allocator] OK");
        end
        else
        begin
            $display("[buddy_block_allocator] ERROR");
        end
        $finish;
    end

endmodule
